// ===== src/sgr_pkg.sv =====
// ----------------------------------------------------------------------------
// SGR attribute decoder package
// Attribute types, SGR code constants, colour palettes and the per-parameter
// update functions shared by the channel interfaces and the decoder.
// ----------------------------------------------------------------------------
package sgr_pkg;

    localparam int PARAM_W = 16;
    localparam int RGB_W   = 24;

    typedef logic [PARAM_W-1:0] sgr_param_t;
    typedef logic [RGB_W-1:0]   rgb_t;

    typedef struct packed {
        rgb_t       fg;
        rgb_t       bg;
        logic [1:0] weight;
        logic       italic;
        logic       underline;
        logic       strike;
    } attr_t;

    // Weights
    localparam logic [1:0] WEIGHT_LIGHT  = 2'd0;
    localparam logic [1:0] WEIGHT_NORMAL = 2'd1;
    localparam logic [1:0] WEIGHT_BOLD   = 2'd2;
    localparam logic [1:0] WEIGHT_BLACK  = 2'd3;

    // Reset values of the default registers
    localparam rgb_t       RST_DEFAULT_FG     = 24'h000000;
    localparam rgb_t       RST_DEFAULT_BG     = 24'hFFFFFF;
    localparam logic [1:0] RST_DEFAULT_WEIGHT = WEIGHT_NORMAL;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_DEFAULT_FG        = 3'd0;
    localparam logic [2:0] REG_DEFAULT_BG        = 3'd1;
    localparam logic [2:0] REG_DEFAULT_WEIGHT    = 3'd2;
    localparam logic [2:0] REG_DEFAULT_ITALIC    = 3'd3;
    localparam logic [2:0] REG_DEFAULT_UNDERLINE = 3'd4;
    localparam logic [2:0] REG_DEFAULT_STRIKE    = 3'd5;

    // SGR codes
    localparam sgr_param_t SGR_RESET          = 16'd0;
    localparam sgr_param_t SGR_BOLD           = 16'd1;
    localparam sgr_param_t SGR_FAINT          = 16'd2;
    localparam sgr_param_t SGR_ITALIC         = 16'd3;
    localparam sgr_param_t SGR_UNDERLINE      = 16'd4;
    localparam sgr_param_t SGR_BLINK          = 16'd5;
    localparam sgr_param_t SGR_RAPID_BLINK    = 16'd6;
    localparam sgr_param_t SGR_INVERSE        = 16'd7;
    localparam sgr_param_t SGR_CONCEAL        = 16'd8;
    localparam sgr_param_t SGR_STRIKE         = 16'd9;
    localparam sgr_param_t SGR_PRIMARY_FONT   = 16'd10;
    localparam sgr_param_t SGR_DBL_UNDERLINE  = 16'd21;
    localparam sgr_param_t SGR_NORMAL_WEIGHT  = 16'd22;
    localparam sgr_param_t SGR_ITALIC_OFF     = 16'd23;
    localparam sgr_param_t SGR_UNDERLINE_OFF  = 16'd24;
    localparam sgr_param_t SGR_BLINK_OFF      = 16'd25;
    localparam sgr_param_t SGR_INVERSE_OFF    = 16'd27;
    localparam sgr_param_t SGR_REVEAL         = 16'd28;
    localparam sgr_param_t SGR_STRIKE_OFF     = 16'd29;
    localparam sgr_param_t SGR_FG_BASE        = 16'd30;
    localparam sgr_param_t SGR_FG_LAST        = 16'd37;
    localparam sgr_param_t SGR_FG_EXT         = 16'd38;
    localparam sgr_param_t SGR_FG_DEFAULT     = 16'd39;
    localparam sgr_param_t SGR_BG_BASE        = 16'd40;
    localparam sgr_param_t SGR_BG_LAST        = 16'd47;
    localparam sgr_param_t SGR_BG_EXT         = 16'd48;
    localparam sgr_param_t SGR_BG_DEFAULT     = 16'd49;
    localparam sgr_param_t SGR_FG_BRIGHT_BASE = 16'd90;
    localparam sgr_param_t SGR_FG_BRIGHT_LAST = 16'd97;
    localparam sgr_param_t SGR_BG_BRIGHT_BASE = 16'd100;
    localparam sgr_param_t SGR_BG_BRIGHT_LAST = 16'd107;

    // Extended colour selectors and index ranges
    localparam sgr_param_t SEL_RGB        = 16'd2;
    localparam sgr_param_t SEL_INDEX      = 16'd5;
    localparam sgr_param_t IDX_BRIGHT     = 16'h0008;
    localparam sgr_param_t IDX_CUBE_FIRST = 16'h0010;
    localparam sgr_param_t IDX_CUBE_LAST  = 16'h00E7;
    localparam sgr_param_t IDX_GREY_FIRST = 16'h00E8;
    localparam sgr_param_t IDX_MAX        = 16'h00FF;
    localparam logic [7:0] CHAN_MAX       = 8'hFF;

    localparam rgb_t PAL_DARK [8] = '{
        24'h000000, 24'h800000, 24'h008000, 24'h808000,
        24'h000080, 24'h800080, 24'h008080, 24'hC0C0C0
    };
    localparam rgb_t PAL_BRIGHT [8] = '{
        24'h808080, 24'hFF0000, 24'h00FF00, 24'hFFFF00,
        24'h0000FF, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF
    };
    // Bright palette with each channel scaled by 0.8, rounded to nearest.
    localparam rgb_t PAL_SCALED [8] = '{
        24'h666666, 24'hCC0000, 24'h00CC00, 24'hCCCC00,
        24'h0000CC, 24'hCC00CC, 24'h00CCCC, 24'hCCCCCC
    };
    localparam logic [7:0] CUBE_LEVEL [6] = '{
        8'd0, 8'd95, 8'd135, 8'd175, 8'd215, 8'd255
    };
    localparam logic [7:0] GREY_LEVEL [24] = '{
        8'd0,   8'd11,  8'd22,  8'd33,  8'd44,  8'd55,  8'd67,  8'd78,
        8'd89,  8'd100, 8'd111, 8'd122, 8'd133, 8'd144, 8'd155, 8'd166,
        8'd177, 8'd188, 8'd200, 8'd211, 8'd222, 8'd233, 8'd244, 8'd255
    };

    function automatic attr_t set_target(attr_t a, logic to_bg, rgb_t rgb);
        attr_t r;
        r = a;
        if (to_bg)
            r.bg = rgb;
        else
            r.fg = rgb;
        return r;
    endfunction

    // Plain SGR code; extended colour codes only start a sequence elsewhere.
    function automatic attr_t apply_code(attr_t a, sgr_param_t p, attr_t dflt);
        attr_t      r;
        rgb_t       tmp;
        sgr_param_t off;
        r   = a;
        tmp = a.fg;
        off = '0;
        case (p)
            SGR_RESET:         r = dflt;
            SGR_BOLD,
            SGR_BLINK:         r.weight = WEIGHT_BOLD;
            SGR_FAINT:         r.weight = WEIGHT_LIGHT;
            SGR_ITALIC:        r.italic = 1'b1;
            SGR_UNDERLINE:     r.underline = 1'b1;
            SGR_RAPID_BLINK:   r.weight = WEIGHT_BLACK;
            SGR_INVERSE,
            SGR_INVERSE_OFF:
            begin
                r.fg = a.bg;
                r.bg = tmp;
            end
            SGR_CONCEAL:       r.fg = a.bg;
            SGR_STRIKE:        r.strike = 1'b1;
            SGR_PRIMARY_FONT:
            begin
                r.weight    = dflt.weight;
                r.italic    = dflt.italic;
                r.underline = dflt.underline;
                r.strike    = dflt.strike;
            end
            SGR_DBL_UNDERLINE,
            SGR_NORMAL_WEIGHT,
            SGR_BLINK_OFF:     r.weight = WEIGHT_NORMAL;
            SGR_ITALIC_OFF:    r.italic = 1'b0;
            SGR_UNDERLINE_OFF,
            SGR_STRIKE_OFF:    r.underline = 1'b0;
            SGR_REVEAL:
            begin
                r.fg = dflt.fg;
                r.bg = dflt.bg;
            end
            SGR_FG_DEFAULT:    r.fg = dflt.fg;
            SGR_BG_DEFAULT:    r.bg = dflt.bg;
            default:
            begin
                if (p >= SGR_FG_BASE && p <= SGR_FG_LAST) begin
                    off = p - SGR_FG_BASE;
                    // Foreground follows the bright palette once the weight is bold or black.
                    r.fg = (a.weight > WEIGHT_NORMAL) ? PAL_BRIGHT[off[2:0]]
                                                      : PAL_DARK[off[2:0]];
                end else if (p >= SGR_BG_BASE && p <= SGR_BG_LAST) begin
                    off  = p - SGR_BG_BASE;
                    r.bg = PAL_BRIGHT[off[2:0]];
                end else if (p >= SGR_FG_BRIGHT_BASE && p <= SGR_FG_BRIGHT_LAST) begin
                    off  = p - SGR_FG_BRIGHT_BASE;
                    r.fg = PAL_SCALED[off[2:0]];
                end else if (p >= SGR_BG_BRIGHT_BASE && p <= SGR_BG_BRIGHT_LAST) begin
                    off  = p - SGR_BG_BRIGHT_BASE;
                    r.bg = PAL_SCALED[off[2:0]];
                end
            end
        endcase
        return r;
    endfunction

    // Colour of one entry of the 6x6x6 cube, k counted from its first entry.
    function automatic rgb_t cube_rgb(logic [7:0] k);
        logic [2:0] ri;
        logic [2:0] gi;
        logic [7:0] rem;
        logic [7:0] bi;
        ri  = 3'(k >= 8'd36) + 3'(k >= 8'd72) + 3'(k >= 8'd108)
            + 3'(k >= 8'd144) + 3'(k >= 8'd180);
        rem = k - 8'(ri) * 8'd36;
        gi  = 3'(rem >= 8'd6) + 3'(rem >= 8'd12) + 3'(rem >= 8'd18)
            + 3'(rem >= 8'd24) + 3'(rem >= 8'd30);
        bi  = rem - 8'(gi) * 8'd6;
        return {CUBE_LEVEL[ri], CUBE_LEVEL[gi], CUBE_LEVEL[bi[2:0]]};
    endfunction

    function automatic attr_t apply_index(attr_t a, sgr_param_t idx, logic to_bg,
                                          attr_t dflt);
        attr_t      r;
        sgr_param_t off;
        logic [7:0] grey;
        r    = a;
        off  = '0;
        grey = '0;
        if (idx < IDX_BRIGHT) begin
            r = apply_code(a, (to_bg ? SGR_BG_BASE : SGR_FG_BASE) + idx, dflt);
        end else if (idx < IDX_CUBE_FIRST) begin
            r = apply_code(a, (to_bg ? SGR_BG_BRIGHT_BASE : SGR_FG_BRIGHT_BASE)
                              + idx - IDX_BRIGHT, dflt);
        end else if (idx <= IDX_CUBE_LAST) begin
            off = idx - IDX_CUBE_FIRST;
            r   = set_target(a, to_bg, cube_rgb(off[7:0]));
        end else if (idx <= IDX_MAX) begin
            off  = idx - IDX_GREY_FIRST;
            grey = GREY_LEVEL[off[4:0]];
            r    = set_target(a, to_bg, {grey, grey, grey});
        end
        return r;
    endfunction

endpackage

// ===== src/sgr_param_if.sv =====
// ----------------------------------------------------------------------------
// SGR parameter channel
// Valid/ready channel carrying one SGR parameter and its framing flags.
// ----------------------------------------------------------------------------
interface sgr_param_if;
    import sgr_pkg::*;

    logic       valid;
    logic       ready;
    sgr_param_t param_value;
    logic       last_param;
    logic       new_text;

    modport source (output valid, output param_value, output last_param,
                    output new_text, input ready);
    modport sink   (input valid, input param_value, input last_param,
                    input new_text, output ready);
endinterface

// ===== src/sgr_attr_if.sv =====
// ----------------------------------------------------------------------------
// SGR attribute channel
// Valid/ready channel carrying the text attributes in force after a parameter.
// ----------------------------------------------------------------------------
interface sgr_attr_if;
    import sgr_pkg::*;

    logic       valid;
    logic       ready;
    rgb_t       fg_color;
    rgb_t       bg_color;
    logic [1:0] weight;
    logic       italic;
    logic       underline;
    logic       strike;

    modport source (output valid, output fg_color, output bg_color, output weight,
                    output italic, output underline, output strike, input ready);
    modport sink   (input valid, input fg_color, input bg_color, input weight,
                    input italic, input underline, input strike, output ready);
endinterface

// ===== src/sgr_text_attribute_decoder.sv =====
// ----------------------------------------------------------------------------
// SGR text attribute decoder
// Applies one SGR parameter per item to the current text attributes and
// reports the attributes after every parameter.
//
// Usage: parameters arrive on the params channel and one attribute item per
// parameter leaves on the attrs channel, both valid/ready. The result of an
// item is shown in the cycle after it is accepted, and one item is taken
// every cycle while the receiver keeps taking results; the whole update
// is a single pass of combinational logic into the attribute registers.
// params.ready is high whenever the result register is empty or is being
// emptied in the same cycle, so a stalled receiver holds off new items
// without losing the pending result. Extended colours (38/48) span several
// items and are collected by a small pending-state register.
// Reset restores the power-on defaults (black on white, normal weight) and
// clears the pending state; the defaults can then be changed through the
// APB port, which should only be written while no items are in flight.
// ----------------------------------------------------------------------------
module sgr_text_attribute_decoder (
    input  logic              clk,
    input  logic              rst_n,
    sgr_param_if.sink         params,
    sgr_attr_if.source        attrs,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import sgr_pkg::*;

    typedef enum logic [2:0] {
        PEND_IDLE  = 3'd0,
        PEND_SEL   = 3'd1,
        PEND_RED   = 3'd2,
        PEND_GREEN = 3'd3,
        PEND_BLUE  = 3'd4,
        PEND_INDEX = 3'd5
    } pend_mode_t;

    // Configuration registers
    rgb_t       default_fg_reg;
    rgb_t       default_bg_reg;
    logic [1:0] default_weight_reg;
    logic       default_italic_reg;
    logic       default_underline_reg;
    logic       default_strike_reg;

    attr_t      dflt;

    // Decoder state; attr_reg doubles as the result register.
    attr_t      attr_reg,      attr_next;
    pend_mode_t mode_reg,      mode_next;
    logic       target_bg_reg, target_bg_next;
    logic [7:0] red_reg,       red_next;
    logic [7:0] green_reg,     green_next;
    logic       out_valid_reg;

    pend_mode_t mode_cur;
    attr_t      attr_cur;
    logic [7:0] sat;
    logic       in_accept;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            default_fg_reg        <= RST_DEFAULT_FG;
            default_bg_reg        <= RST_DEFAULT_BG;
            default_weight_reg    <= RST_DEFAULT_WEIGHT;
            default_italic_reg    <= 1'b0;
            default_underline_reg <= 1'b0;
            default_strike_reg    <= 1'b0;
        end else if (cfg_write) begin
            case (paddr[4:2])
                REG_DEFAULT_FG:        default_fg_reg        <= pwdata[23:0];
                REG_DEFAULT_BG:        default_bg_reg        <= pwdata[23:0];
                REG_DEFAULT_WEIGHT:    default_weight_reg    <= pwdata[1:0];
                REG_DEFAULT_ITALIC:    default_italic_reg    <= pwdata[0];
                REG_DEFAULT_UNDERLINE: default_underline_reg <= pwdata[0];
                REG_DEFAULT_STRIKE:    default_strike_reg    <= pwdata[0];
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_DEFAULT_FG:        prdata = {8'd0, default_fg_reg};
            REG_DEFAULT_BG:        prdata = {8'd0, default_bg_reg};
            REG_DEFAULT_WEIGHT:    prdata = {30'd0, default_weight_reg};
            REG_DEFAULT_ITALIC:    prdata = {31'd0, default_italic_reg};
            REG_DEFAULT_UNDERLINE: prdata = {31'd0, default_underline_reg};
            REG_DEFAULT_STRIKE:    prdata = {31'd0, default_strike_reg};
            default:               prdata = '0;
        endcase
    end

    assign dflt = '{fg: default_fg_reg, bg: default_bg_reg,
                    weight: default_weight_reg, italic: default_italic_reg,
                    underline: default_underline_reg, strike: default_strike_reg};

    assign sat = (params.param_value > sgr_param_t'(CHAN_MAX)) ? CHAN_MAX
                                                              : params.param_value[7:0];

    always_comb
    begin
        attr_cur       = attr_reg;
        mode_cur       = mode_reg;
        target_bg_next = target_bg_reg;
        red_next       = red_reg;
        green_next     = green_reg;

        // A new text run starts from the defaults with no colour pending.
        if (params.new_text) begin
            attr_cur = dflt;
            mode_cur = PEND_IDLE;
        end

        attr_next = attr_cur;
        mode_next = PEND_IDLE;
        case (mode_cur)
            PEND_IDLE:
            begin
                attr_next = apply_code(attr_cur, params.param_value, dflt);
                if (params.param_value == SGR_FG_EXT || params.param_value == SGR_BG_EXT)
                begin
                    mode_next      = PEND_SEL;
                    target_bg_next = (params.param_value == SGR_BG_EXT);
                end
            end
            PEND_SEL:
            begin
                if (params.param_value == SEL_RGB)
                    mode_next = PEND_RED;
                else if (params.param_value == SEL_INDEX)
                    mode_next = PEND_INDEX;
            end
            PEND_RED:
            begin
                red_next  = sat;
                mode_next = PEND_GREEN;
            end
            PEND_GREEN:
            begin
                green_next = sat;
                mode_next  = PEND_BLUE;
            end
            PEND_BLUE:
                attr_next = set_target(attr_cur, target_bg_reg, {red_reg, green_reg, sat});
            PEND_INDEX:
                attr_next = apply_index(attr_cur, params.param_value, target_bg_reg, dflt);
            default:
                mode_next = PEND_IDLE;
        endcase

        // The end of a sequence drops any half-collected colour.
        if (params.last_param)
            mode_next = PEND_IDLE;
    end

    assign params.ready = !out_valid_reg || attrs.ready;
    assign in_accept    = params.valid && params.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            attr_reg      <= '{fg: RST_DEFAULT_FG, bg: RST_DEFAULT_BG,
                               weight: RST_DEFAULT_WEIGHT, italic: 1'b0,
                               underline: 1'b0, strike: 1'b0};
            mode_reg      <= PEND_IDLE;
            target_bg_reg <= 1'b0;
            red_reg       <= '0;
            green_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_accept) begin
                attr_reg      <= attr_next;
                mode_reg      <= mode_next;
                target_bg_reg <= target_bg_next;
                red_reg       <= red_next;
                green_reg     <= green_next;
                out_valid_reg <= 1'b1;
            end else if (attrs.ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign attrs.valid     = out_valid_reg;
    assign attrs.fg_color  = attr_reg.fg;
    assign attrs.bg_color  = attr_reg.bg;
    assign attrs.weight    = attr_reg.weight;
    assign attrs.italic    = attr_reg.italic;
    assign attrs.underline = attr_reg.underline;
    assign attrs.strike    = attr_reg.strike;

endmodule
